[src/mandel_pkg.sv]
// Shared constants, register indexes and the sat32 helper of the Mandelbrot escape-time core.
package mandel_pkg;

  localparam int COORD_W  = 32;
  localparam int PROD_W   = 64;
  localparam int FRAC_W   = 26;
  localparam int COL_W    = 12;
  localparam int ROW_W    = 12;
  localparam int COUNT_W  = 16;
  localparam int WIDTH_W  = 13;
  localparam int PIX_W    = 24;
  localparam int CFG_IDX_W = 3;

  localparam int IN_DATA_W  = COL_W + ROW_W;
  localparam int OUT_DATA_W = COUNT_W + PIX_W;

  localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd5;

  localparam logic signed [COORD_W-1:0] RST_X_ORIGIN = -32'sd134217728;
  localparam logic signed [COORD_W-1:0] RST_Y_ORIGIN = -32'sd134217728;
  localparam logic signed [COORD_W-1:0] RST_X_STEP   = 32'sd262144;
  localparam logic signed [COORD_W-1:0] RST_Y_STEP   = 32'sd262144;
  localparam logic [COUNT_W-1:0]        RST_MAX_ITER = 16'd1000;
  localparam logic [WIDTH_W-1:0]        RST_WIDTH    = 13'd1024;

  // Escape threshold 4.0 in the Q12.52 format of a squared magnitude.
  localparam logic [PROD_W-1:0] ESCAPE_LIMIT = 64'd4 << (2 * FRAC_W);

  localparam logic signed [PROD_W-1:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [PROD_W-1:0] SAT_MIN = -64'sd2147483648;

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[COORD_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

[src/mandelbrot_escape_time_core.sv]
// Top level of the Mandelbrot escape-time core: sequencer around one shared multiplier.
//
// Usage: each input word on in_* names one pixel by column and row. The core
// forms c from the origin and step registers and iterates z = z^2 + c in
// Q6.26 fixed point until |z|^2 reaches 4 or max_iterations is reached. One
// output word on out_* carries the iteration count and the pixel index
// row*image_width + column (modulo 2^24).
// Configuration is written through cfg_we/cfg_index/cfg_wdata while idle; the
// user must keep to this, as the block does not enforce it. An item runs
// through PCX, PCY, PIX and PIXA, then loops CHK, XY, UPD, SQX and SQY. Every
// multiplication, point forming and the pixel index included, goes through
// one signed 33x33 multiplier; one iteration uses it for x*y, x*x and y*y
// plus one update and one compare step. in_tready is high only while no item
// is in work, so a new item is taken only after the last one has left CHK.
// The result sits in an output register; a new item may be accepted while it
// waits. If the receiver stalls, a finished item holds at its final compare
// until the output register is free. Reset (rst_n low at a clock edge) loads
// the register defaults, drops out_tvalid and returns the sequencer to idle.
module mandelbrot_escape_time_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // Fields from bit 0: column[11:0], row[23:12].
  input  logic [mandel_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // Fields from bit 0: iteration_count[15:0], pixel_index[39:16].
  output logic [mandel_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                  cfg_we,
  input  logic [mandel_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mandel_pkg::COORD_W-1:0]        cfg_wdata
);
  import mandel_pkg::*;

  localparam int MUL_W = COORD_W + 1;
  localparam int ST_W  = 4;

  localparam logic [ST_W-1:0] ST_IDLE = 4'd0;
  localparam logic [ST_W-1:0] ST_PCX  = 4'd1;
  localparam logic [ST_W-1:0] ST_PCY  = 4'd2;
  localparam logic [ST_W-1:0] ST_PIX  = 4'd3;
  localparam logic [ST_W-1:0] ST_PIXA = 4'd4;
  localparam logic [ST_W-1:0] ST_CHK  = 4'd5;
  localparam logic [ST_W-1:0] ST_XY   = 4'd6;
  localparam logic [ST_W-1:0] ST_UPD  = 4'd7;
  localparam logic [ST_W-1:0] ST_SQX  = 4'd8;
  localparam logic [ST_W-1:0] ST_SQY  = 4'd9;

  logic [ST_W-1:0] state_r, state_nxt;

  logic signed [COORD_W-1:0] x_origin_r, y_origin_r, x_step_r, y_step_r;
  logic [COUNT_W-1:0]        max_iter_r;
  logic [WIDTH_W-1:0]        width_r;

  logic [COL_W-1:0]          col_r;
  logic [ROW_W-1:0]          row_r;
  logic signed [COORD_W-1:0] cx_r, cy_r, x_r, y_r;
  logic signed [PROD_W-1:0]  xx_r, yy_r, xy_r, re_r;
  logic [COUNT_W-1:0]        count_r;
  logic [PIX_W-1:0]          pix_r;

  logic                      out_valid_r;
  logic [COUNT_W-1:0]        out_count_r;
  logic [PIX_W-1:0]          out_pix_r;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p;
  logic [PROD_W-1:0]         mag_sum;
  logic                      finished;
  logic                      out_free;
  logic                      in_acc;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_pix_r, out_count_r};
  assign out_free   = !out_valid_r || out_tready;

  assign mag_sum  = xx_r + yy_r;
  assign finished = (count_r >= max_iter_r) || (mag_sum >= ESCAPE_LIMIT);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_PCX: begin
        mul_a = $signed({{(MUL_W-COL_W){1'b0}}, col_r});
        mul_b = MUL_W'(x_step_r);
      end
      ST_PCY: begin
        mul_a = $signed({{(MUL_W-ROW_W){1'b0}}, row_r});
        mul_b = MUL_W'(y_step_r);
      end
      ST_PIX: begin
        mul_a = $signed({{(MUL_W-ROW_W){1'b0}}, row_r});
        mul_b = $signed({{(MUL_W-WIDTH_W){1'b0}}, width_r});
      end
      ST_XY: begin
        mul_a = MUL_W'(x_r);
        mul_b = MUL_W'(y_r);
      end
      ST_SQX: begin
        mul_a = MUL_W'(x_r);
        mul_b = MUL_W'(x_r);
      end
      ST_SQY: begin
        mul_a = MUL_W'(y_r);
        mul_b = MUL_W'(y_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_PCX;
      ST_PCX:  state_nxt = ST_PCY;
      ST_PCY:  state_nxt = ST_PIX;
      ST_PIX:  state_nxt = ST_PIXA;
      ST_PIXA: state_nxt = ST_CHK;
      ST_CHK: begin
        if (!finished) begin
          state_nxt = ST_XY;
        end else if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_XY:   state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_SQX;
      ST_SQX:  state_nxt = ST_SQY;
      ST_SQY:  state_nxt = ST_CHK;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      x_origin_r  <= RST_X_ORIGIN;
      y_origin_r  <= RST_Y_ORIGIN;
      x_step_r    <= RST_X_STEP;
      y_step_r    <= RST_Y_STEP;
      max_iter_r  <= RST_MAX_ITER;
      width_r     <= RST_WIDTH;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_index)
          REG_X_ORIGIN: x_origin_r <= cfg_wdata;
          REG_Y_ORIGIN: y_origin_r <= cfg_wdata;
          REG_X_STEP:   x_step_r   <= cfg_wdata;
          REG_Y_STEP:   y_step_r   <= cfg_wdata;
          REG_MAX_ITER: max_iter_r <= cfg_wdata[COUNT_W-1:0];
          REG_WIDTH:    width_r    <= cfg_wdata[WIDTH_W-1:0];
          default: ;
        endcase
      end

      if ((state_r == ST_CHK) && finished && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            col_r   <= in_tdata[COL_W-1:0];
            row_r   <= in_tdata[IN_DATA_W-1:COL_W];
            count_r <= '0;
            x_r     <= '0;
            y_r     <= '0;
          end
        end
        ST_PCX: xy_r <= mul_p[PROD_W-1:0];
        ST_PCY: begin
          cx_r <= sat32(xy_r + PROD_W'(x_origin_r));
          xy_r <= mul_p[PROD_W-1:0];
        end
        ST_PIX: begin
          cy_r <= sat32(xy_r + PROD_W'(y_origin_r));
          xy_r <= mul_p[PROD_W-1:0];
        end
        ST_PIXA: begin
          pix_r <= xy_r[PIX_W-1:0] + PIX_W'(col_r);
          xx_r  <= '0;
          yy_r  <= '0;
        end
        ST_CHK: begin
          if (finished && out_free) begin
            out_count_r <= count_r;
            out_pix_r   <= pix_r;
          end
        end
        ST_XY: begin
          xy_r <= mul_p[PROD_W-1:0];
          re_r <= xx_r - yy_r;
        end
        ST_UPD: begin
          x_r     <= sat32((re_r >>> FRAC_W) + PROD_W'(cx_r));
          y_r     <= sat32((xy_r >>> (FRAC_W - 1)) + PROD_W'(cy_r));
          count_r <= count_r + COUNT_W'(1);
        end
        ST_SQX: xx_r <= mul_p[PROD_W-1:0];
        ST_SQY: yy_r <= mul_p[PROD_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[src/mandel_chk.sv]
// Port-level assertions of the Mandelbrot escape-time core and their bind.
module mandel_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [mandel_pkg::OUT_DATA_W-1:0] out_tdata
);
  import mandel_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Stalled output word changed or dropped.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("Core ready again right after taking a word.");

  a_busy_only_by_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(in_tvalid && in_tready))
    else $error("Core went busy without taking a word.");

  a_done_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> in_tready)
    else $error("Result shown while the core is still busy.");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("Reset did not clear the output and the sequencer.");

endmodule

bind mandelbrot_escape_time_core mandel_chk u_mandel_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[test/mandelbrot_escape_time_core_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the Mandelbrot escape-time core with a scoreboard and random views.
module tb;
  import mandel_pkg::*;

  localparam int HALF_PERIOD = 5;
  localparam int WATCHDOG_LIMIT = 100000;
  localparam int HOLD_CYCLES = 500;
  localparam int COST_CAP = 2000;
  localparam int PHASE_ITEMS = 72;
  localparam int PHASES = 8;
  localparam int DEEP_PHASE = 5;
  localparam int PRESSURE_PHASE = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam longint ONE_Q26 = 64'sd67108864;
  localparam longint unsigned ESCAPE_SQ = 64'd4 << (2 * FRAC_W);

  typedef struct {
    logic [COL_W-1:0]   column;
    logic [ROW_W-1:0]   row;
    logic [COUNT_W-1:0] count;
    logic [PIX_W-1:0]   pixel;
  } pixel_result_t;

  class pixel_scoreboard;
    logic signed [COORD_W-1:0] x_origin, y_origin, x_step, y_step;
    logic [COUNT_W-1:0] iter_limit;
    logic [WIDTH_W-1:0] row_width;
    pixel_result_t expected_q[$];
    int mismatches;

    function new();
      reset_regs();
      mismatches = 0;
    endfunction

    function void reset_regs();
      x_origin = RST_X_ORIGIN;
      y_origin = RST_Y_ORIGIN;
      x_step = RST_X_STEP;
      y_step = RST_Y_STEP;
      iter_limit = RST_MAX_ITER;
      row_width = RST_WIDTH;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] index, logic [COORD_W-1:0] data);
      case (index)
        REG_X_ORIGIN: x_origin = data;
        REG_Y_ORIGIN: y_origin = data;
        REG_X_STEP: x_step = data;
        REG_Y_STEP: y_step = data;
        REG_MAX_ITER: iter_limit = data[COUNT_W-1:0];
        REG_WIDTH: row_width = data[WIDTH_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Stops early once cap iterations are done, so callers can bound the cost of a pixel.
    function int unsigned escape_count(logic [COL_W-1:0] column, logic [ROW_W-1:0] row,
                                       int unsigned cap);
      longint cx, cy, zx, zy, re, im;
      longint unsigned mag;
      int unsigned n;
      cx = clamp32(longint'(column) * longint'(x_step) + longint'(x_origin));
      cy = clamp32(longint'(row) * longint'(y_step) + longint'(y_origin));
      zx = 0;
      zy = 0;
      mag = 0;
      n = 0;
      while (n < iter_limit && n < cap && mag < ESCAPE_SQ) begin
        re = zx * zx - zy * zy;
        im = zx * zy;
        zx = clamp32((re >>> FRAC_W) + cx);
        zy = clamp32((im >>> (FRAC_W - 1)) + cy);
        mag = zx * zx;
        mag = mag + zy * zy;
        n++;
      end
      return n;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_pixel(logic [COL_W-1:0] column, logic [ROW_W-1:0] row);
      pixel_result_t e;
      logic [31:0] lin;
      e.column = column;
      e.row = row;
      e.count = COUNT_W'(escape_count(column, row, 32'hFFFF_FFFF));
      lin = 32'(row) * 32'(row_width) + 32'(column);
      e.pixel = lin[PIX_W-1:0];
      expected_q.push_back(e);
    endfunction

    task report_mismatch(string what, longint unsigned want, longint unsigned got);
      $display("MISMATCH %s: expected %0d, got %0d", what, want, got);
      mismatches++;
    endtask

    task check_result(logic [OUT_DATA_W-1:0] word);
      pixel_result_t e;
      if (expected_q.size() == 0) begin
        report_mismatch("output word with nothing pending", 0, word);
      end else begin
        e = expected_q.pop_front();
        if (word[COUNT_W-1:0] !== e.count) begin
          report_mismatch($sformatf("iteration_count of pixel (%0d,%0d)", e.column, e.row),
                          e.count, word[COUNT_W-1:0]);
        end
        if (word[COUNT_W +: PIX_W] !== e.pixel) begin
          report_mismatch($sformatf("pixel_index of pixel (%0d,%0d)", e.column, e.row),
                          e.pixel, word[COUNT_W +: PIX_W]);
        end
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  // Fields from bit 0: column[11:0], row[23:12].
  logic [IN_DATA_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  // Fields from bit 0: iteration_count[15:0], pixel_index[39:16].
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COORD_W-1:0] cfg_wdata;

  int src_idle_pct;
  int sink_stall_pct;
  bit hold_req;
  bit hold_ack;
  int quiet_cycles;
  pixel_scoreboard sb;

  mandelbrot_escape_time_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  initial begin
    out_tready = 1'b0;
    hold_ack = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_ack) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_ack = hold_req;
      end
      out_tready = ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata);
    end
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [COORD_W-1:0] data);
    cfg_we = 1'b1;
    cfg_index = index;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(index, data);
  endtask

  task automatic send_pixel(input logic [COL_W-1:0] column, input logic [ROW_W-1:0] row);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid = 1'b0;
      in_tdata = IN_DATA_W'($urandom);
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {row, column};
    do @(posedge clk); while (!in_tready);
    sb.note_pixel(column, row);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [COORD_W-1:0] q26_pick(input longint lo, input longint span);
    longint v;
    v = lo + longint'($urandom_range(span));
    return v[COORD_W-1:0];
  endfunction

  function automatic logic [COORD_W-1:0] step_pick();
    longint m;
    m = longint'($urandom_range(65536));
    if ($urandom_range(1)) m = -m;
    return m[COORD_W-1:0];
  endfunction

  // Most views frame the set itself; the rest use raw register values, which can saturate c.
  task automatic pick_view(input bit deep);
    logic [COORD_W-1:0] w;
    logic [COUNT_W-1:0] limit;
    logic [WIDTH_W-1:0] cols;
    int sel;
    sel = $urandom_range(9);
    if (sel < 7 || deep) begin
      write_reg(REG_X_ORIGIN, q26_pick(-(5 * ONE_Q26) / 2, 3 * ONE_Q26));
      write_reg(REG_Y_ORIGIN, q26_pick(-(3 * ONE_Q26) / 2, 3 * ONE_Q26));
      write_reg(REG_X_STEP, step_pick());
      write_reg(REG_Y_STEP, step_pick());
    end else begin
      write_reg(REG_X_ORIGIN, $urandom);
      write_reg(REG_Y_ORIGIN, $urandom);
      write_reg(REG_X_STEP, $urandom);
      write_reg(REG_Y_STEP, $urandom);
    end
    if (deep) begin
      limit = 16'hFFFF;
    end else if ($urandom_range(9) == 0) begin
      limit = COUNT_W'($urandom_range(400, 65));
    end else begin
      limit = COUNT_W'($urandom_range(64, 1));
    end
    w = $urandom;
    w[COUNT_W-1:0] = limit;
    write_reg(REG_MAX_ITER, w);
    sel = $urandom_range(9);
    if (sel == 0) begin
      cols = '0;
    end else if (sel == 1) begin
      cols = WIDTH_W'($urandom_range(8191, 4097));
    end else begin
      cols = WIDTH_W'($urandom_range(4096, 1));
    end
    w = $urandom;
    w[WIDTH_W-1:0] = cols;
    write_reg(REG_WIDTH, w);
  endtask

  task automatic run_random(input int count);
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    int tries;
    int unsigned cost;
    for (int k = 0; k < count; k++) begin
      tries = 0;
      do begin
        column = COL_W'($urandom);
        row = ROW_W'($urandom);
        cost = sb.escape_count(column, row, COST_CAP + 1);
        tries++;
      end while (cost > COST_CAP && tries < 50);
      if (cost <= COST_CAP) begin
        send_pixel(column, row);
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    hold_req = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset view: corners, an edge point, the origin, the period-two point and the cusp.
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(512, 512);
    send_pixel(256, 512);
    send_pixel(576, 512);
    send_pixel(1023, 0);
    send_pixel(100, 4095);
    drain();
    write_reg(REG_MAX_ITER, 32'hFFFF_0000);
    send_pixel(512, 512);
    send_pixel(4095, 0);
    drain();
    write_reg(REG_MAX_ITER, 32'd1);
    write_reg(REG_WIDTH, 32'd0);
    send_pixel(512, 512);
    send_pixel(4095, 4095);
    drain();
    write_reg(REG_WIDTH, 32'd8191);
    send_pixel(4095, 4095);
    drain();
    write_reg(REG_WIDTH, 32'hFFFF_F000);
    send_pixel(4095, 4095);
    send_pixel(0, 1);
    drain();
    write_reg(REG_X_ORIGIN, 32'h7FFF_FFFF);
    write_reg(REG_X_STEP, 32'h7FFF_FFFF);
    write_reg(REG_Y_ORIGIN, 32'h8000_0000);
    write_reg(REG_Y_STEP, 32'h8000_0000);
    write_reg(REG_MAX_ITER, 32'd3);
    send_pixel(4095, 4095);
    send_pixel(0, 0);
    send_pixel(1, 1);
    drain();
    write_reg(REG_SPARE_LO, 32'd0);
    write_reg(REG_SPARE_HI, 32'hFFFF_FFFF);
    send_pixel(0, 0);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      pick_view(p == DEEP_PHASE);
      case (p % 4)
        0: begin
          src_idle_pct = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct = 85;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          sink_stall_pct = 85;
        end
        default: begin
          src_idle_pct = 12;
          sink_stall_pct = 12;
        end
      endcase
      run_random(PHASE_ITEMS);
      if (p == PRESSURE_PHASE) begin
        drain();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_req = ~hold_req;
        run_random(24);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
src/mandel_pkg.sv
src/mandelbrot_escape_time_core.sv
src/mandel_chk.sv
test/mandelbrot_escape_time_core_tb.sv
